### hdl/b2da_pkg.sv
// ----------------------------------------------------------------------------
// b2da_pkg: shared types and constants of the binary to decimal ascii unit
// digit widths, ascii offset, queue entry and front state machine codes
// ----------------------------------------------------------------------------
package b2da_pkg;

   localparam int VALUE_W     = 32;              // width of the input value field
   localparam int MAX_DIGITS  = 10;              // decimal digits of a 32-bit value
   localparam int DIGIT_W     = 4;               // one bcd digit
   localparam int DIGIT_IDX_W = $clog2(MAX_DIGITS);
   localparam int BCD_W       = MAX_DIGITS * DIGIT_W;
   localparam int CHAR_W      = 6;               // width of the ascii digit field
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;
   localparam logic [DIGIT_W-1:0] DABBLE_MIN = 4'd5;   // digit that needs the correction
   localparam logic [DIGIT_W-1:0] DABBLE_ADD = 4'd3;

   typedef logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digits_type;

   // one converted number waiting for the back end
   typedef struct packed {
      digits_type             digits;
      logic [DIGIT_IDX_W-1:0] top_idx;   // most significant digit to emit
   } entry_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_CONVERT,
      FRONT_PUSH
   } front_state_type;

endpackage

### hdl/b2da_req_if.sv
// ----------------------------------------------------------------------------
// b2da_req_if: input channel of the binary to decimal ascii unit
// valid/ready handshake carrying one binary value per beat
// ----------------------------------------------------------------------------
interface b2da_req_if;

   logic                         valid;
   logic                         ready;
   logic [b2da_pkg::VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);

endinterface

### hdl/b2da_rsp_if.sv
// ----------------------------------------------------------------------------
// b2da_rsp_if: result channel of the binary to decimal ascii unit
// valid/ready handshake carrying one ascii digit per beat
// ----------------------------------------------------------------------------
interface b2da_rsp_if;

   logic                        valid;
   logic                        ready;
   logic [b2da_pkg::CHAR_W-1:0] digit_char;
   logic                        last_digit;

   modport source (output valid, output digit_char, output last_digit, input ready);
   modport sink   (input valid, input digit_char, input last_digit, output ready);

endinterface

### hdl/binary_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_unit: unsigned binary to decimal ascii text
// converts one value per request beat into a run of ascii digit beats
// ----------------------------------------------------------------------------
// Each request beat carries a 32-bit unsigned value, of which the low
// VALUE_BITS bits (all 32 when VALUE_BITS is 32 or more) are converted. The
// response is a run of ascii digits '0'..'9', most significant first, with
// leading zeros dropped; last_digit marks the final digit. Zero gives the
// single digit '0'. The front end takes a value and runs a shift-and-add-3
// conversion one bit per cycle, and takes the next request only after the
// converted value has been pushed into the queue. A two-entry queue feeds
// the back end, which picks up each entry and then sends one digit per cycle
// while the sink is ready, so a run of digits hides under the next conversion.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_unit #(
   parameter int VALUE_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   b2da_req_if.sink   req_bus,
   b2da_rsp_if.source rsp_bus
);

   // front to queue
   logic                push_valid;
   logic                push_ready;
   b2da_pkg::entry_type push_entry;

   // queue to back
   logic                pop_valid;
   logic                pop_ready;
   b2da_pkg::entry_type pop_entry;

   // bit-serial conversion and top digit search
   b2da_front #(
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   // decouples conversion from a stalled display
   b2da_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // digit emission with registered output
   b2da_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp_bus   (rsp_bus)
   );

endmodule

### hdl/b2da_front.sv
// ----------------------------------------------------------------------------
// b2da_front: input side of the converter
// takes a value, runs shift-and-add-3 one bit per cycle, finds the top digit
// ----------------------------------------------------------------------------
module b2da_front #(
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   b2da_req_if.sink              req_bus,
   output logic                  push_valid,
   input  logic                  push_ready,
   output b2da_pkg::entry_type   push_entry
);

   localparam int EFF_BITS = (VALUE_BITS < b2da_pkg::VALUE_W) ? VALUE_BITS
                                                               : b2da_pkg::VALUE_W;
   localparam int CNT_W    = $clog2(EFF_BITS + 1);

   b2da_pkg::front_state_type state_ff, state_in;

   logic [EFF_BITS-1:0]          bin_ff, bin_in;
   b2da_pkg::digits_type         bcd_ff, bcd_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;

   b2da_pkg::digits_type         adj;
   logic [b2da_pkg::BCD_W-1:0]   adj_flat;
   logic [b2da_pkg::DIGIT_IDX_W-1:0] top_idx;

   logic load, shift;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         b2da_pkg::FRONT_IDLE: begin
            if (req_bus.valid) state_in = b2da_pkg::FRONT_CONVERT;
         end
         b2da_pkg::FRONT_CONVERT: begin
            if (cnt_ff == CNT_W'(1)) state_in = b2da_pkg::FRONT_PUSH;
         end
         b2da_pkg::FRONT_PUSH: begin
            if (push_ready) state_in = b2da_pkg::FRONT_IDLE;
         end
         default: state_in = b2da_pkg::FRONT_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_bus.ready = 1'b0;
      push_valid    = 1'b0;
      load          = 1'b0;
      shift         = 1'b0;
      unique case (state_ff)
         b2da_pkg::FRONT_IDLE: begin
            req_bus.ready = 1'b1;
            load          = req_bus.valid;
         end
         b2da_pkg::FRONT_CONVERT: begin
            shift = 1'b1;
         end
         b2da_pkg::FRONT_PUSH: begin
            push_valid = 1'b1;
         end
         default: begin
            req_bus.ready = 1'b0;
         end
      endcase
   end

   // add 3 to every digit of 5 or more, then shift in the next binary bit
   always_comb begin
      for (int i = 0; i < b2da_pkg::MAX_DIGITS; i++) begin
         adj[i] = (bcd_ff[i] >= b2da_pkg::DABBLE_MIN) ? bcd_ff[i] + b2da_pkg::DABBLE_ADD
                                                      : bcd_ff[i];
      end
      adj_flat = adj;
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      cnt_in = cnt_ff;
      if (load) begin
         bin_in = req_bus.value[EFF_BITS-1:0];
         bcd_in = '0;
         cnt_in = CNT_W'(EFF_BITS);
      end else if (shift) begin
         bin_in = bin_ff << 1;
         bcd_in = {adj_flat[b2da_pkg::BCD_W-2:0], bin_ff[EFF_BITS-1]};
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   // highest nonzero digit, digit zero when the value is zero
   always_comb begin
      top_idx = '0;
      for (int i = 1; i < b2da_pkg::MAX_DIGITS; i++) begin
         if (bcd_ff[i] != '0) top_idx = b2da_pkg::DIGIT_IDX_W'(i);
      end
   end

   assign push_entry.digits  = bcd_ff;
   assign push_entry.top_idx = top_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= b2da_pkg::FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
   end

endmodule

### hdl/b2da_queue.sv
// ----------------------------------------------------------------------------
// b2da_queue: short fifo between front and back
// holds converted numbers so both sides stall on their own
// ----------------------------------------------------------------------------
module b2da_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  b2da_pkg::entry_type push_entry,
   output logic                pop_valid,
   input  logic                pop_ready,
   output b2da_pkg::entry_type pop_entry
);

   localparam int PTR_W = $clog2(b2da_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(b2da_pkg::QUEUE_DEPTH + 1);

   b2da_pkg::entry_type slot_ff [b2da_pkg::QUEUE_DEPTH];

   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign push_ready = (cnt_ff != CNT_W'(b2da_pkg::QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_entry  = slot_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(b2da_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(b2da_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) cnt_in = cnt_ff + CNT_W'(1);
      else if (!do_push && do_pop) cnt_in = cnt_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) slot_ff[wr_ff] <= push_entry;
   end

endmodule

### hdl/b2da_back.sv
// ----------------------------------------------------------------------------
// b2da_back: output side of the converter
// walks the digits of one entry from the top down into a registered output
// ----------------------------------------------------------------------------
module b2da_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  b2da_pkg::entry_type pop_entry,
   b2da_rsp_if.source          rsp_bus
);

   logic                             busy_ff, busy_in;
   b2da_pkg::digits_type             digits_ff, digits_in;
   logic [b2da_pkg::DIGIT_IDX_W-1:0] idx_ff, idx_in;
   logic                             out_valid_ff, out_valid_in;
   logic [b2da_pkg::CHAR_W-1:0]      char_ff, char_in;
   logic                             last_ff, last_in;
   logic                             out_free;

   assign out_free  = !out_valid_ff || rsp_bus.ready;
   assign pop_ready = !busy_ff;

   always_comb begin
      busy_in      = busy_ff;
      digits_in    = digits_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      if (rsp_bus.ready) out_valid_in = 1'b0;
      if (!busy_ff) begin
         if (pop_valid) begin
            busy_in   = 1'b1;
            digits_in = pop_entry.digits;
            idx_in    = pop_entry.top_idx;
         end
      end else if (out_free) begin
         out_valid_in = 1'b1;
         char_in      = b2da_pkg::ASCII_ZERO + {2'b00, digits_ff[idx_ff]};
         last_in      = (idx_ff == '0);
         if (idx_ff == '0) busy_in = 1'b0;
         else              idx_in  = idx_ff - b2da_pkg::DIGIT_IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
      digits_ff <= digits_in;
      idx_ff    <= idx_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.digit_char = char_ff;
   assign rsp_bus.last_digit = last_ff;

endmodule
